@@ hdl/char_lcd_nibble_write_sequencer_defines.svh @@
// Assertion macros shared by the checker of the LCD nibble write sequencer.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define CLNWS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define CLNWS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/clnws_pkg.sv @@
// Types, codes and constants shared by the LCD nibble write sequencer modules.
package clnws_pkg;

    localparam int unsigned REG_W      = 16;
    localparam int unsigned HOLD_W     = 18;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned CMD_IDX_W  = 3;

    localparam logic [OP_W-1:0] OP_CMD  = 2'd0;
    localparam logic [OP_W-1:0] OP_DATA = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PULSE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_RECOVERY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_SETTLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP_WAIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DONE_WAIT  = 3'd4;

    localparam logic [REG_W-1:0] RST_ENABLE_PULSE    = 16'd1;
    localparam logic [REG_W-1:0] RST_ENABLE_RECOVERY = 16'd100;
    localparam logic [REG_W-1:0] RST_BYTE_SETTLE     = 16'd2000;
    localparam logic [REG_W-1:0] RST_POWER_UP_WAIT   = 16'd50000;
    localparam logic [REG_W-1:0] RST_INIT_DONE_WAIT  = 16'd5000;

    localparam logic [CMD_IDX_W-1:0] INIT_LAST_IDX = 3'd5;
    localparam logic [1:0]           PHASE_LAST    = 2'd3;

    // Fixed initialisation commands, sent in index order.
    function automatic logic [7:0] init_cmd(input logic [CMD_IDX_W-1:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h33;
            3'd1:    val = 8'h32;
            3'd2:    val = 8'h28;
            3'd3:    val = 8'h0C;
            3'd4:    val = 8'h06;
            3'd5:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // Controller to datapath command for the current cycle.
    typedef struct packed {
        logic                 load;
        logic                 emit;
        logic                 power;
        logic [1:0]           phase;
        logic [CMD_IDX_W-1:0] cmd_idx;
        logic                 fin;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic slot_free;
    } dp_status_t;

endpackage

@@ hdl/clnws_ctrl.sv @@
// Controller state machine that steps through the pin states of one request.
module clnws_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [clnws_pkg::OP_W-1:0]    opcode,
    output logic                          in_stall,
    input  clnws_pkg::dp_status_t         status,
    output clnws_pkg::dp_cmd_t            cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_POWER = 3'b010,
        ST_BYTE  = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    logic [1:0]                          phase_reg, phase_next;
    logic [clnws_pkg::CMD_IDX_W-1:0]     idx_reg, idx_next;
    logic                                init_reg, init_next;
    logic                                accept;
    logic                                fin;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign fin      = (phase_reg == clnws_pkg::PHASE_LAST) &&
                      (!init_reg || (idx_reg == clnws_pkg::INIT_LAST_IDX));

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        init_next   = init_reg;
        cmd.load    = accept;
        cmd.emit    = 1'b0;
        cmd.power   = (state_reg == ST_POWER);
        cmd.phase   = phase_reg;
        cmd.cmd_idx = idx_reg;
        cmd.fin     = fin;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    phase_next = 2'd0;
                    idx_next   = '0;
                    init_next  = (opcode == clnws_pkg::OP_INIT);
                    if (opcode == clnws_pkg::OP_INIT)
                    begin
                        state_next = ST_POWER;
                    end
                    else if (opcode != clnws_pkg::OP_NONE)
                    begin
                        state_next = ST_BYTE;
                    end
                end
            end
            ST_POWER:
            begin
                cmd.fin = 1'b0;
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_BYTE;
                end
            end
            ST_BYTE:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    phase_next = phase_reg + 2'd1;
                    if (phase_reg == clnws_pkg::PHASE_LAST)
                    begin
                        if (fin)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 3'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 2'd0;
            idx_reg   <= '0;
            init_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            init_reg  <= init_next;
        end
    end

endmodule

@@ hdl/clnws_datapath.sv @@
// Datapath: timing registers, latched request and the output pin-state register.
module clnws_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [clnws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [clnws_pkg::REG_W-1:0]       cfg_data,
    input  logic [clnws_pkg::OP_W-1:0]        opcode,
    input  logic [7:0]                        byte_value,
    input  clnws_pkg::dp_cmd_t                cmd,
    output clnws_pkg::dp_status_t             status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              reg_select,
    output logic                              enable_level,
    output logic [3:0]                        bus_nibble,
    output logic [clnws_pkg::HOLD_W-1:0]      hold_us,
    output logic                              last
);

    logic [clnws_pkg::REG_W-1:0]  pulse_reg, recovery_reg, settle_reg;
    logic [clnws_pkg::REG_W-1:0]  power_reg, done_reg;
    logic [clnws_pkg::OP_W-1:0]   op_reg;
    logic [7:0]                   byte_reg;
    logic                         out_valid_reg;
    logic                         rs_reg, en_reg, last_reg;
    logic [3:0]                   nib_reg;
    logic [clnws_pkg::HOLD_W-1:0] hold_reg;

    logic                         is_init;
    logic [7:0]                   cur_byte;
    logic                         rs_next, en_next, last_next;
    logic [3:0]                   nib_next;
    logic [clnws_pkg::HOLD_W-1:0] hold_next;
    logic [clnws_pkg::REG_W-1:0]  extra;

    assign status.slot_free = !out_valid_reg || !out_stall;

    assign is_init  = (op_reg == clnws_pkg::OP_INIT);
    assign cur_byte = is_init ? clnws_pkg::init_cmd(cmd.cmd_idx) : byte_reg;
    assign extra    = (is_init && cmd.fin) ? done_reg : '0;

    always_comb
    begin
        if (cmd.power)
        begin
            rs_next   = 1'b0;
            en_next   = 1'b0;
            nib_next  = 4'h0;
            hold_next = {2'b00, power_reg};
            last_next = 1'b0;
        end
        else
        begin
            rs_next   = (op_reg == clnws_pkg::OP_DATA);
            en_next   = !cmd.phase[0];
            nib_next  = cmd.phase[1] ? cur_byte[3:0] : cur_byte[7:4];
            last_next = cmd.fin;
            unique case (cmd.phase)
                2'd0, 2'd2: hold_next = {2'b00, pulse_reg};
                2'd1:       hold_next = {2'b00, recovery_reg};
                default:    hold_next = {2'b00, recovery_reg} + {2'b00, settle_reg}
                                        + {2'b00, extra};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg    <= clnws_pkg::RST_ENABLE_PULSE;
            recovery_reg <= clnws_pkg::RST_ENABLE_RECOVERY;
            settle_reg   <= clnws_pkg::RST_BYTE_SETTLE;
            power_reg    <= clnws_pkg::RST_POWER_UP_WAIT;
            done_reg     <= clnws_pkg::RST_INIT_DONE_WAIT;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                clnws_pkg::CFG_ENABLE_PULSE:    pulse_reg    <= cfg_data;
                clnws_pkg::CFG_ENABLE_RECOVERY: recovery_reg <= cfg_data;
                clnws_pkg::CFG_BYTE_SETTLE:     settle_reg   <= cfg_data;
                clnws_pkg::CFG_POWER_UP_WAIT:   power_reg    <= cfg_data;
                clnws_pkg::CFG_INIT_DONE_WAIT:  done_reg     <= cfg_data;
                default:                        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            byte_reg <= byte_value;
        end
        if (cmd.emit)
        begin
            rs_reg   <= rs_next;
            en_reg   <= en_next;
            nib_reg  <= nib_next;
            hold_reg <= hold_next;
            last_reg <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign reg_select   = rs_reg;
    assign enable_level = en_reg;
    assign bus_nibble   = nib_reg;
    assign hold_us      = hold_reg;
    assign last         = last_reg;

endmodule

@@ hdl/char_lcd_nibble_write_sequencer.sv @@
// Top level of the 4-bit character LCD write sequencer.
// A request's first pin state is registered after the controller leaves idle, when the output slot is free.
// Throughput: one pin state per cycle from the state machine when the output is not stalled;
// a byte request gives four pin states, initialisation a wait state plus four per command.
// A new request is taken only once the last pin state of the current one is registered.
// Reset: rst_n clears the controller and output valid and restores the timing registers.
module char_lcd_nibble_write_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [clnws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [clnws_pkg::REG_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [clnws_pkg::OP_W-1:0]        opcode,
    input  logic [7:0]                        byte_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              reg_select,
    output logic                              enable_level,
    output logic [3:0]                        bus_nibble,
    output logic [clnws_pkg::HOLD_W-1:0]      hold_us,
    output logic                              last
);

    clnws_pkg::dp_cmd_t    cmd;
    clnws_pkg::dp_status_t status;

    clnws_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    clnws_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .byte_value   (byte_value),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .reg_select   (reg_select),
        .enable_level (enable_level),
        .bus_nibble   (bus_nibble),
        .hold_us      (hold_us),
        .last         (last)
    );

endmodule

@@ hdl/clnws_checker.sv @@
// Port-level checker for the LCD nibble write sequencer and its bind statement.
`include "char_lcd_nibble_write_sequencer_defines.svh"

module clnws_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              enable_level,
    input logic [3:0]                        bus_nibble,
    input logic [clnws_pkg::HOLD_W-1:0]      hold_us,
    input logic                              last
);

    `CLNWS_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(bus_nibble) && $stable(hold_us) && $stable(last),
        "stalled result changed or was dropped")

    `CLNWS_ASSERT_IMP(a_busy_mid_request, out_valid && !last, in_stall,
        "new request accepted before the current one finished")

    `CLNWS_ASSERT_NXT(a_no_gap, out_valid && !last && !out_stall, out_valid,
        "gap in the pin states of one request")

    `CLNWS_ASSERT_NXT(a_strobe_fall, out_valid && enable_level && !out_stall,
        out_valid && !enable_level && (bus_nibble == $past(bus_nibble)),
        "enable high state not followed by enable low on the same nibble")

endmodule

bind char_lcd_nibble_write_sequencer clnws_checker u_clnws_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .enable_level (enable_level),
    .bus_nibble   (bus_nibble),
    .hold_us      (hold_us),
    .last         (last)
);

@@ dv/char_lcd_nibble_write_sequencer_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts and compares the pin states of the LCD nibble write sequencer.
module char_lcd_nibble_write_sequencer_checker
    import clnws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [OP_W-1:0]      opcode,
    input  logic [7:0]           byte_value,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 reg_select,
    input  logic                 enable_level,
    input  logic [3:0]           bus_nibble,
    input  logic [HOLD_W-1:0]    hold_us,
    input  logic                 last,
    output int                   fail_count,
    output int                   outstanding
);

    localparam int          INIT_COUNT = 6;
    // Initialisation commands, first one in the top byte.
    localparam logic [47:0] INIT_BYTES = 48'h33_32_28_0C_06_01;

    typedef struct packed {
        logic              rs;
        logic              en;
        logic [3:0]        nibble;
        logic [HOLD_W-1:0] hold;
        logic              fin;
    } pin_state_t;

    logic [REG_W-1:0] pulse_us;
    logic [REG_W-1:0] recovery_us;
    logic [REG_W-1:0] settle_us;
    logic [REG_W-1:0] power_wait_us;
    logic [REG_W-1:0] done_wait_us;
    pin_state_t       pin_queue[$];

    initial fail_count = 0;

    function automatic pin_state_t make_pin(input logic rs, input logic en,
                                            input logic [3:0] nibble,
                                            input logic [HOLD_W-1:0] hold,
                                            input logic fin);
        pin_state_t st;
        st.rs     = rs;
        st.en     = en;
        st.nibble = nibble;
        st.hold   = hold;
        st.fin    = fin;
        return st;
    endfunction

    function automatic void queue_byte(input logic rs, input logic [7:0] value,
                                       input logic [HOLD_W-1:0] extra, input logic fin);
        logic [HOLD_W-1:0] tail_hold;
        tail_hold = HOLD_W'(recovery_us) + HOLD_W'(settle_us) + extra;
        pin_queue.push_back(make_pin(rs, 1'b1, value[7:4], HOLD_W'(pulse_us), 1'b0));
        pin_queue.push_back(make_pin(rs, 1'b0, value[7:4], HOLD_W'(recovery_us), 1'b0));
        pin_queue.push_back(make_pin(rs, 1'b1, value[3:0], HOLD_W'(pulse_us), 1'b0));
        pin_queue.push_back(make_pin(rs, 1'b0, value[3:0], tail_hold, fin));
    endfunction

    function automatic void predict_request(input logic [OP_W-1:0] op,
                                            input logic [7:0] value);
        if (op == OP_CMD || op == OP_DATA)
        begin
            queue_byte(op == OP_DATA, value, '0, 1'b1);
        end
        else if (op == OP_INIT)
        begin
            pin_queue.push_back(make_pin(1'b0, 1'b0, 4'h0, HOLD_W'(power_wait_us), 1'b0));
            for (int i = 0; i < INIT_COUNT; i++)
            begin
                queue_byte(1'b0, INIT_BYTES[8*(INIT_COUNT-1-i) +: 8],
                           (i == INIT_COUNT - 1) ? HOLD_W'(done_wait_us) : '0,
                           i == INIT_COUNT - 1);
            end
        end
        // The unused opcode produces nothing.
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pin_state_t want;
        if (!rst_n)
        begin
            pulse_us      = RST_ENABLE_PULSE;
            recovery_us   = RST_ENABLE_RECOVERY;
            settle_us     = RST_BYTE_SETTLE;
            power_wait_us = RST_POWER_UP_WAIT;
            done_wait_us  = RST_INIT_DONE_WAIT;
            pin_queue.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_ENABLE_PULSE:    pulse_us      = cfg_data;
                    CFG_ENABLE_RECOVERY: recovery_us   = cfg_data;
                    CFG_BYTE_SETTLE:     settle_us     = cfg_data;
                    CFG_POWER_UP_WAIT:   power_wait_us = cfg_data;
                    CFG_INIT_DONE_WAIT:  done_wait_us  = cfg_data;
                    default:             ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_request(opcode, byte_value);
            if (out_valid && !out_stall)
            begin
                if (pin_queue.size() == 0)
                begin
                    $display({"%0t: pin state with none expected: ",
                              "rs %0d en %0d nibble %0h hold %0d last %0d"},
                             $time, reg_select, enable_level, bus_nibble, hold_us, last);
                    fail_count++;
                end
                else
                begin
                    want = pin_queue.pop_front();
                    check_field("reg_select", 32'(want.rs), 32'(reg_select));
                    check_field("enable_level", 32'(want.en), 32'(enable_level));
                    check_field("bus_nibble", 32'(want.nibble), 32'(bus_nibble));
                    check_field("hold_us", 32'(want.hold), 32'(hold_us));
                    check_field("last", 32'(want.fin), 32'(last));
                end
            end
            // Registered so that the stimulus sees a count that includes this edge.
            outstanding <= pin_queue.size();
        end
    end

endmodule

@@ dv/char_lcd_nibble_write_sequencer_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the LCD nibble write sequencer: clock, reset, stimulus and verdict.
module char_lcd_nibble_write_sequencer_test;
    import clnws_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 90;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [REG_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      opcode       = OP_CMD;
    logic [7:0]           byte_value   = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic                 reg_select;
    logic                 enable_level;
    logic [3:0]           bus_nibble;
    logic [HOLD_W-1:0]    hold_us;
    logic                 last;
    int                   fail_count;
    int                   outstanding;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_ticket    = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    char_lcd_nibble_write_sequencer u_dut (.*);

    char_lcd_nibble_write_sequencer_checker u_checker (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever a new ticket is issued.
    always @(posedge clk)
    begin
        if (hold_ticket != hold_served)
        begin
            hold_served <= hold_ticket;
            hold_left   <= LONG_HOLD;
            out_stall   <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        byte_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops offering requests until every expected pin state has been seen.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
    endtask

    task automatic load_timing(input logic [REG_W-1:0] pulse, input logic [REG_W-1:0] recovery,
                               input logic [REG_W-1:0] settle, input logic [REG_W-1:0] power,
                               input logic [REG_W-1:0] done_wait);
        write_reg(CFG_ENABLE_PULSE, pulse);
        write_reg(CFG_ENABLE_RECOVERY, recovery);
        write_reg(CFG_BYTE_SETTLE, settle);
        write_reg(CFG_POWER_UP_WAIT, power);
        write_reg(CFG_INIT_DONE_WAIT, done_wait);
        cfg_write_en <= 1'b0;
    endtask

    task automatic load_random_timing();
        load_timing(REG_W'($urandom_range(65535)), REG_W'($urandom_range(65535)),
                    REG_W'($urandom_range(65535)), REG_W'($urandom_range(65535)),
                    REG_W'($urandom_range(65535)));
    endtask

    task automatic run_random(input int count, input bit with_pause, input bit with_hold);
        int unsigned roll;
        logic [OP_W-1:0] op;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
                op = OP_CMD;
            else if (roll < 80)
                op = OP_DATA;
            else if (roll < 95)
                op = OP_INIT;
            else
                op = OP_NONE;
            // The sender keeps going during the hold-off so that the block backs up.
            if (with_hold && i == 10)
                hold_ticket <= hold_ticket + 1;
            if (with_pause && i == count / 2)
                wait_idle();
            send_request(op, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset timing.
        send_request(OP_CMD, 8'h00);
        send_request(OP_DATA, 8'hFF);
        send_request(OP_CMD, 8'hA5);
        send_request(OP_DATA, 8'h5A);
        send_request(OP_INIT, 8'hFF);
        send_request(OP_NONE, 8'hFF);
        send_request(OP_CMD, 8'h0F);
        wait_idle();

        load_timing('1, '1, '1, '1, '1);
        send_request(OP_INIT, 8'h00);
        send_request(OP_DATA, 8'hFF);
        send_request(OP_CMD, 8'hF0);
        wait_idle();

        load_timing('0, '0, '0, '0, '0);
        send_request(OP_INIT, 8'h5A);
        send_request(OP_DATA, 8'h81);
        send_request(OP_NONE, 8'h00);
        wait_idle();

        // Writes to indexes beyond the last register must leave the timing alone.
        for (int idx = CFG_INIT_DONE_WAIT + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), '1);
        cfg_write_en <= 1'b0;
        send_request(OP_DATA, 8'h3C);
        send_request(OP_INIT, 8'hC3);
        wait_idle();

        load_random_timing();
        send_idle_pct   = 9;
        recv_stall_pct <= 57;
        run_random(PHASE_ITEMS, 1'b1, 1'b0);
        wait_idle();

        load_timing('1, '1, '1, '1, '1);
        send_idle_pct   = 57;
        recv_stall_pct <= 9;
        run_random(PHASE_ITEMS, 1'b0, 1'b0);
        wait_idle();

        load_random_timing();
        send_idle_pct   = 0;
        recv_stall_pct <= 0;
        run_random(PHASE_ITEMS, 1'b0, 1'b1);
        wait_idle();

        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/clnws_pkg.sv
hdl/clnws_ctrl.sv
hdl/clnws_datapath.sv
hdl/char_lcd_nibble_write_sequencer.sv
hdl/clnws_checker.sv
dv/char_lcd_nibble_write_sequencer_checker.sv
dv/char_lcd_nibble_write_sequencer_test.sv
